### hw/rtl/btns_pkg.sv
package btns_pkg;

   typedef enum logic [2:0] {
      OP_REGISTER = 3'd0,
      OP_FIND     = 3'd1,
      OP_ADD_E    = 3'd2,
      OP_ADD_P    = 3'd3,
      OP_CLEAR    = 3'd4,
      OP_READ     = 3'd5
   } opcode_type;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_MISS     = 2'd1;
   localparam logic [1:0] ST_BAD_SURF = 2'd2;

   localparam logic [2:0] SURF_TOP    = 3'd0;
   localparam logic [2:0] SURF_RIGHT  = 3'd1;
   localparam logic [2:0] SURF_BOTTOM = 3'd2;
   localparam logic [2:0] SURF_LEFT   = 3'd3;
   localparam logic [2:0] SURF_FRONT  = 3'd4;
   localparam logic [2:0] SURF_BACK   = 3'd5;

   // Byte address of the match tolerance register.
   localparam logic [1:0] CSR_ADDR_TOL = 2'd0;

   // 15 mm in 1/16 mm units.
   localparam logic signed [23:0] SIDE_OFFSET = 24'sd240;

   // Position part of one table entry.
   typedef struct packed {
      logic [2:0]         surface;
      logic signed [23:0] gz;
      logic signed [23:0] gy;
      logic signed [23:0] gx;
   } geom_type;

   typedef struct packed {
      logic [39:0] energy;
      logic [31:0] photons;
   } totals_type;

   typedef struct packed {
      logic [2:0]         block_surface;
      logic signed [23:0] global_z;
      logic signed [23:0] global_y;
      logic signed [23:0] global_x;
      logic [31:0]        photon_total;
      logic [39:0]        energy_total;
      logic [5:0]         result_id;
      logic [1:0]         status;
   } rsp_type;

   // Times ten as two shifts and an add; 20-bit input fits easily in 24 bits.
   function automatic logic signed [23:0] times_ten(input logic signed [19:0] v);
      logic signed [23:0] w;
      begin
         w = 24'(v);
         times_ten = (w <<< 3) + (w <<< 1);
      end
   endfunction

endpackage

### hw/rtl/btns_dist.sv
// Squared distance pipeline: two register stages between input and output.
module btns_dist (
   input  logic               clock,
   input  logic signed [19:0] px,
   input  logic signed [19:0] py,
   input  logic signed [19:0] pz,
   input  btns_pkg::geom_type geom,
   output logic [50:0]        dist_sq
);
   logic signed [25:0] dx_ff, dy_ff, dz_ff;
   logic [49:0] sx_ff, sy_ff, sz_ff;
   logic signed [25:0] dx_in, dy_in, dz_in;

   always_comb begin
      dx_in = 26'(px) - 26'(geom.gx);
      dy_in = 26'(py) - 26'(geom.gy);
      dz_in = 26'(pz) - 26'(geom.gz);
   end

   always_ff @(posedge clock) begin
      dx_ff <= dx_in;
      dy_ff <= dy_in;
      dz_ff <= dz_in;
      sx_ff <= 50'(dx_ff * dx_ff);
      sy_ff <= 50'(dy_ff * dy_ff);
      sz_ff <= 50'(dz_ff * dz_ff);
   end

   assign dist_sq = 51'(sx_ff) + 51'(sy_ff) + 51'(sz_ff);
endmodule

### hw/rtl/block_table_nearest_search.sv
// Block table with nearest-block search. Register, add, read and unknown opcodes pass through
// a read state, in which the entry memory is read, and an execute state, which writes back any
// update and loads the result once the output register is free. Find walks every table
// entry through a two-stage squared-distance pipeline at one entry per cycle, drains that
// pipeline and then, if an entry matched, fetches it through the read and execute states.
// Clear sweeps the totals memory one entry per cycle. One item is in work at a time; a new
// one is taken while the previous result waits in the output register. There is no clearing
// pass after reset.
module block_table_nearest_search #(
   parameter int unsigned BLOCKS = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // opcode[2:0], block_id[8:3], pos_x[28:9], pos_y[48:29], pos_z[68:49],
   // surface[71:69], amount[95:72]
   input  logic [95:0]  req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // status[1:0], result_id[7:2], energy_total[47:8], photon_total[79:48],
   // global_x[103:80], global_y[127:104], global_z[151:128], block_surface[154:152]
   output logic [159:0] rsp_tdata,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [1:0]   csr_paddr,
   input  logic [31:0]  csr_pwdata,
   output logic [31:0]  csr_prdata,
   output logic         csr_pready
);
   localparam int unsigned AW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
   localparam int unsigned CW = $clog2(BLOCKS + 1);

   typedef enum logic [2:0] {
      S_IDLE, S_READ, S_EXEC, S_SCAN, S_DRAIN, S_DONE
   } state_type;

   // Memories.
   btns_pkg::geom_type   geom_mem   [BLOCKS];
   btns_pkg::totals_type totals_mem [BLOCKS];
   logic [BLOCKS-1:0]    valid_ff;

   // CSR.
   logic [19:0] tol_ff;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr == btns_pkg::CSR_ADDR_TOL) ? {12'd0, tol_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= 20'd1600;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr == btns_pkg::CSR_ADDR_TOL) begin
         tol_ff <= csr_pwdata[19:0];
      end
   end

   // Request fields.
   logic [2:0]         op_ff;
   logic [5:0]         id_ff;
   logic signed [19:0] px_ff, py_ff, pz_ff;
   logic [2:0]         surf_ff;
   logic [23:0]        amt_ff;

   state_type     state_ff;
   logic [CW-1:0] addr_ff;     // sweep address for find and clear
   logic [CW-1:0] cmp_ff;      // drain counter for find
   logic [2:0]    vpipe_ff;    // valid bits travelling with memory read + dist stages
   logic [AW-1:0] ipipe_ff [3];
   logic [51:0]   best_ff;
   logic          found_ff;
   logic [AW-1:0] best_id_ff;

   btns_pkg::rsp_type rsp_ff;
   logic              rsp_valid_ff;

   btns_pkg::geom_type   geom_rd_ff;
   btns_pkg::totals_type tot_rd_ff;

   logic [AW-1:0] rd_addr;
   logic          in_table;
   logic          req_fire;
   logic          rsp_free;
   logic          rsp_load;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !reset;
   assign req_fire   = req_tvalid && req_tready;
   assign in_table   = 32'(id_ff) < BLOCKS;

   // A result is loaded from execute, and from done unless a find still fetches its match.
   assign rsp_load = rsp_free && (state_ff == S_EXEC ||
                     (state_ff == S_DONE && !(op_ff == btns_pkg::OP_FIND && found_ff)));

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff};

   always_comb begin
      if (state_ff == S_SCAN) rd_addr = addr_ff[AW-1:0];
      else                    rd_addr = id_ff[AW-1:0];
   end

   // Synchronous reads.
   always_ff @(posedge clock) begin
      geom_rd_ff <= geom_mem[rd_addr];
      tot_rd_ff  <= totals_mem[rd_addr];
   end

   logic [50:0] dist_sq;
   btns_dist u_dist (
      .clock   (clock),
      .px      (px_ff),
      .py      (py_ff),
      .pz      (pz_ff),
      .geom    (geom_rd_ff),
      .dist_sq (dist_sq)
   );

   // Register transform.
   logic signed [23:0] xt, yt, zt, ys;
   btns_pkg::geom_type new_geom;
   always_comb begin
      xt = btns_pkg::times_ten(px_ff);
      zt = btns_pkg::times_ten(pz_ff);
      ys = btns_pkg::times_ten(py_ff);
      yt = ys + btns_pkg::SIDE_OFFSET;
      new_geom.surface = surf_ff;
      new_geom.gz = zt;
      case (surf_ff)
         btns_pkg::SURF_TOP: begin
            new_geom.gx = xt;  new_geom.gy = yt;
         end
         btns_pkg::SURF_RIGHT: begin
            new_geom.gx = -yt; new_geom.gy = xt;
         end
         btns_pkg::SURF_BOTTOM: begin
            new_geom.gx = -xt; new_geom.gy = -yt;
         end
         btns_pkg::SURF_LEFT: begin
            new_geom.gx = yt;  new_geom.gy = -xt;
         end
         btns_pkg::SURF_FRONT: begin
            new_geom.gx = xt;  new_geom.gy = zt; new_geom.gz = -ys;
         end
         default: begin
            new_geom.gx = xt;  new_geom.gy = zt; new_geom.gz = ys;
         end
      endcase
   end

   // Saturating adds.
   logic [40:0] e_sum;
   logic [32:0] p_sum;
   btns_pkg::totals_type add_tot;
   always_comb begin
      e_sum = 41'(tot_rd_ff.energy) + 41'(amt_ff);
      p_sum = 33'(tot_rd_ff.photons) + 33'(amt_ff);
      add_tot = tot_rd_ff;
      if (op_ff == btns_pkg::OP_ADD_E) begin
         add_tot.energy = e_sum[40] ? '1 : e_sum[39:0];
      end else begin
         add_tot.photons = p_sum[32] ? '1 : p_sum[31:0];
      end
   end

   logic [51:0] tol_sq;
   assign tol_sq = 52'(tol_ff) * 52'(tol_ff);

   function automatic btns_pkg::rsp_type block_rsp(
      input logic [5:0] rid, input btns_pkg::geom_type g, input btns_pkg::totals_type t);
      btns_pkg::rsp_type r;
      begin
         r.status        = btns_pkg::ST_OK;
         r.result_id     = rid;
         r.energy_total  = t.energy;
         r.photon_total  = t.photons;
         r.global_x      = g.gx;
         r.global_y      = g.gy;
         r.global_z      = g.gz;
         r.block_surface = g.surface;
         block_rsp = r;
      end
   endfunction

   function automatic btns_pkg::rsp_type err_rsp(input logic [1:0] st, input logic [5:0] rid);
      btns_pkg::rsp_type r;
      begin
         r = '0;
         r.status    = st;
         r.result_id = rid;
         err_rsp = r;
      end
   endfunction

   // Result of the execute cycle.
   btns_pkg::rsp_type exec_rsp;
   always_comb begin
      exec_rsp = err_rsp(btns_pkg::ST_MISS, id_ff);
      case (op_ff)
         btns_pkg::OP_REGISTER: begin
            if (surf_ff > btns_pkg::SURF_BACK) begin
               exec_rsp = err_rsp(btns_pkg::ST_BAD_SURF, id_ff);
            end else if (in_table) begin
               exec_rsp = block_rsp(id_ff, new_geom, '0);
            end
         end
         btns_pkg::OP_ADD_E, btns_pkg::OP_ADD_P: begin
            if (in_table && valid_ff[id_ff[AW-1:0]])
               exec_rsp = block_rsp(id_ff, geom_rd_ff, add_tot);
         end
         btns_pkg::OP_READ: begin
            if (in_table && valid_ff[id_ff[AW-1:0]])
               exec_rsp = block_rsp(id_ff, geom_rd_ff, tot_rd_ff);
         end
         default: ;
      endcase
   end

   // Register and add writes happen once, at the edge that leaves execute; clear writes each swept entry.
   always_ff @(posedge clock) begin
      if (state_ff == S_EXEC && rsp_free && in_table) begin
         if (op_ff == btns_pkg::OP_REGISTER && surf_ff <= btns_pkg::SURF_BACK) begin
            geom_mem[id_ff[AW-1:0]]   <= new_geom;
            totals_mem[id_ff[AW-1:0]] <= '0;
         end else if ((op_ff == btns_pkg::OP_ADD_E || op_ff == btns_pkg::OP_ADD_P)
                      && valid_ff[id_ff[AW-1:0]]) begin
            totals_mem[id_ff[AW-1:0]] <= add_tot;
         end
      end else if (state_ff == S_SCAN && op_ff == btns_pkg::OP_CLEAR) begin
         totals_mem[addr_ff[AW-1:0]] <= '0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         px_ff   <= req_tdata[28:9];
         py_ff   <= req_tdata[48:29];
         pz_ff   <= req_tdata[68:49];
         surf_ff <= req_tdata[71:69];
         amt_ff  <= req_tdata[95:72];
      end
      ipipe_ff[0] <= addr_ff[AW-1:0];
      ipipe_ff[1] <= ipipe_ff[0];
      ipipe_ff[2] <= ipipe_ff[1];
   end

   logic last_addr;
   assign last_addr = (addr_ff == CW'(BLOCKS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         vpipe_ff     <= '0;
         found_ff     <= 1'b0;
         addr_ff      <= '0;
         cmp_ff       <= '0;
      end else begin
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  state_ff <= S_READ;
                  op_ff    <= req_tdata[2:0];
                  id_ff    <= req_tdata[8:3];
               end
            end
            S_READ: begin
               addr_ff  <= '0;
               cmp_ff   <= '0;
               vpipe_ff <= '0;
               found_ff <= 1'b0;
               best_ff  <= tol_sq;
               best_id_ff <= '0;
               if (op_ff == btns_pkg::OP_FIND || op_ff == btns_pkg::OP_CLEAR) begin
                  state_ff <= S_SCAN;
               end else begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (rsp_free) begin
                  state_ff <= S_IDLE;
                  rsp_ff   <= exec_rsp;
                  if (op_ff == btns_pkg::OP_REGISTER && surf_ff <= btns_pkg::SURF_BACK
                      && in_table)
                     valid_ff[id_ff[AW-1:0]] <= 1'b1;
               end
            end
            S_SCAN: begin
               addr_ff  <= addr_ff + 1'b1;
               vpipe_ff <= {vpipe_ff[1:0],
                            (op_ff == btns_pkg::OP_FIND) && valid_ff[addr_ff[AW-1:0]]};
               if (last_addr) state_ff <= (op_ff == btns_pkg::OP_FIND) ? S_DRAIN : S_DONE;
            end
            S_DRAIN: begin
               vpipe_ff <= {vpipe_ff[1:0], 1'b0};
               cmp_ff   <= cmp_ff + 1'b1;
               if (vpipe_ff == 3'd0 && cmp_ff != '0) state_ff <= S_DONE;
            end
            S_DONE: begin
               if (op_ff == btns_pkg::OP_FIND && found_ff) begin
                  // Fetch the matched entry for the response.
                  id_ff    <= 6'(best_id_ff);
                  op_ff    <= btns_pkg::OP_READ;
                  state_ff <= S_READ;
               end else if (rsp_free) begin
                  state_ff <= S_IDLE;
                  if (op_ff == btns_pkg::OP_FIND) begin
                     rsp_ff <= err_rsp(btns_pkg::ST_MISS, 6'd0);
                  end else begin
                     rsp_ff <= err_rsp(btns_pkg::ST_OK, id_ff);
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
         if (vpipe_ff[2] && 52'(dist_sq) < best_ff) begin
            best_ff    <= 52'(dist_sq);
            best_id_ff <= ipipe_ff[2];
            found_ff   <= 1'b1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_tready |=> rsp_valid_ff)
      else $error("result dropped while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff == S_READ)
      else $error("accepted item not started");
   assert property (@(posedge clock) disable iff (reset)
      found_ff |-> best_ff < tol_sq || best_ff == tol_sq)
      else $error("best distance above tolerance");
   assert property (@(posedge clock) disable iff (reset)
      state_ff != S_IDLE |-> !req_tready)
      else $error("ready while busy");
endmodule

### dv/testbench.sv
module testbench;

   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [23:0]        amount;
      logic [2:0]         surface;
      logic signed [19:0] pz;
      logic signed [19:0] py;
      logic signed [19:0] px;
      logic [5:0]         block_id;
      logic [2:0]         opcode;
   } req_item_type;

   localparam logic [39:0] ENERGY_MAX = 40'hFF_FFFF_FFFF;
   localparam logic [31:0] PHOTON_MAX = 32'hFFFF_FFFF;
   localparam logic [2:0]  OP_BAD6 = 3'd6;
   localparam logic [2:0]  OP_BAD7 = 3'd7;
   localparam int          LIMIT_CYCLES = 900000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [95:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [159:0] rsp_tdata;
   logic csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic csr_pready;

   block_table_nearest_search uut (.*);

   always #4 clock = ~clock;

   // Mirror of the block table.
   logic        tbl_valid [64];
   logic [2:0]  tbl_surf [64];
   logic signed [23:0] tbl_gx [64], tbl_gy [64], tbl_gz [64];
   logic [39:0] tbl_energy [64];
   logic [31:0] tbl_photons [64];
   logic [19:0] tolerance;

   req_item_type      pending_items[$];
   btns_pkg::rsp_type expected_rsps[$];
   int  failures = 0;
   int  cycles = 0;
   bit  calm = 1'b0;
   bit  drive_go = 1'b0;

   function automatic btns_pkg::rsp_type block_fields(btns_pkg::rsp_type r, int i);
      r.energy_total  = tbl_energy[i];
      r.photon_total  = tbl_photons[i];
      r.global_x      = tbl_gx[i];
      r.global_y      = tbl_gy[i];
      r.global_z      = tbl_gz[i];
      r.block_surface = tbl_surf[i];
      return r;
   endfunction

   function automatic btns_pkg::rsp_type apply_request(req_item_type t);
      btns_pkg::rsp_type r;
      logic signed [23:0] xs, ys, zs;
      logic [63:0] best, d2;
      logic signed [63:0] dx, dy, dz;
      logic [40:0] esum;
      logic [32:0] psum;
      int id;
      bit found;
      r = '0;
      r.status = btns_pkg::ST_MISS;
      r.result_id = t.block_id;
      id = t.block_id;
      case (t.opcode)
         btns_pkg::OP_REGISTER: begin
            xs = 24'(t.px) * 10;
            ys = 24'(t.py) * 10;
            zs = 24'(t.pz) * 10;
            if (t.surface > btns_pkg::SURF_BACK) begin
               r.status = btns_pkg::ST_BAD_SURF;
            end else begin
               case (t.surface)
                  btns_pkg::SURF_TOP: begin
                     tbl_gx[id] = xs; tbl_gy[id] = ys + btns_pkg::SIDE_OFFSET;
                  end
                  btns_pkg::SURF_RIGHT: begin
                     tbl_gx[id] = -(ys + btns_pkg::SIDE_OFFSET); tbl_gy[id] = xs;
                  end
                  btns_pkg::SURF_BOTTOM: begin
                     tbl_gx[id] = -xs; tbl_gy[id] = -(ys + btns_pkg::SIDE_OFFSET);
                  end
                  btns_pkg::SURF_LEFT: begin
                     tbl_gx[id] = ys + btns_pkg::SIDE_OFFSET; tbl_gy[id] = -xs;
                  end
                  default: begin
                     tbl_gx[id] = xs;
                     tbl_gy[id] = zs;
                  end
               endcase
               if (t.surface == btns_pkg::SURF_FRONT) tbl_gz[id] = -ys;
               else if (t.surface == btns_pkg::SURF_BACK) tbl_gz[id] = ys;
               else tbl_gz[id] = zs;
               tbl_valid[id] = 1'b1;
               tbl_surf[id] = t.surface;
               tbl_energy[id] = '0;
               tbl_photons[id] = '0;
               r.status = btns_pkg::ST_OK;
               r = block_fields(r, id);
            end
         end
         btns_pkg::OP_FIND: begin
            best = 64'(tolerance) * 64'(tolerance);
            found = 1'b0;
            id = 0;
            for (int i = 0; i < 64; i++) begin
               if (tbl_valid[i]) begin
                  dx = 64'(t.px) - 64'(tbl_gx[i]);
                  dy = 64'(t.py) - 64'(tbl_gy[i]);
                  dz = 64'(t.pz) - 64'(tbl_gz[i]);
                  d2 = dx * dx + dy * dy + dz * dz;
                  if (d2 < best) begin
                     best = d2;
                     id = i;
                     found = 1'b1;
                  end
               end
            end
            r.result_id = '0;
            if (found) begin
               r.status = btns_pkg::ST_OK;
               r.result_id = 6'(id);
               r = block_fields(r, id);
            end
         end
         btns_pkg::OP_ADD_E, btns_pkg::OP_ADD_P: begin
            if (tbl_valid[id]) begin
               if (t.opcode == btns_pkg::OP_ADD_E) begin
                  esum = 41'(tbl_energy[id]) + 41'(t.amount);
                  tbl_energy[id] = esum[40] ? ENERGY_MAX : esum[39:0];
               end else begin
                  psum = 33'(tbl_photons[id]) + 33'(t.amount);
                  tbl_photons[id] = psum[32] ? PHOTON_MAX : psum[31:0];
               end
               r.status = btns_pkg::ST_OK;
               r = block_fields(r, id);
            end
         end
         btns_pkg::OP_CLEAR: begin
            for (int i = 0; i < 64; i++) begin
               tbl_energy[i] = '0;
               tbl_photons[i] = '0;
            end
            r.status = btns_pkg::ST_OK;
         end
         btns_pkg::OP_READ: begin
            if (tbl_valid[id]) begin
               r.status = btns_pkg::ST_OK;
               r = block_fields(r, id);
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic bit idle_now();
      return !calm && ($urandom_range(99) < 14);
   endfunction

   function automatic void enqueue(req_item_type t);
      pending_items = {pending_items, t};
   endfunction

   // Request driver.
   always @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         expected_rsps = {expected_rsps, apply_request(req_item_type'(req_tdata))};
         void'(pending_items.pop_front());
      end
      if (reset || !drive_go) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_tready)) begin
         if (pending_items.size() > 0 && !idle_now()) begin
            req_tvalid <= 1'b1;
            req_tdata  <= pending_items[0];
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Response monitor and checker.
   always @(posedge clock) begin
      btns_pkg::rsp_type got, want;
      cycles <= cycles + 1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = btns_pkg::rsp_type'(rsp_tdata[154:0]);
         if (expected_rsps.size() == 0) begin
            $error("unexpected response transfer %h", rsp_tdata);
            failures <= failures + 1;
         end else begin
            want = expected_rsps.pop_front();
            if (got != want) begin
               failures <= failures + 1;
               if (got.status != want.status)
                  $error("status exp %0d got %0d", want.status, got.status);
               if (got.result_id != want.result_id)
                  $error("result_id exp %0d got %0d", want.result_id, got.result_id);
               if (got.energy_total != want.energy_total)
                  $error("energy_total exp %0d got %0d", want.energy_total, got.energy_total);
               if (got.photon_total != want.photon_total)
                  $error("photon_total exp %0d got %0d", want.photon_total, got.photon_total);
               if (got.global_x != want.global_x)
                  $error("global_x exp %0d got %0d", want.global_x, got.global_x);
               if (got.global_y != want.global_y)
                  $error("global_y exp %0d got %0d", want.global_y, got.global_y);
               if (got.global_z != want.global_z)
                  $error("global_z exp %0d got %0d", want.global_z, got.global_z);
               if (got.block_surface != want.block_surface)
                  $error("block_surface exp %0d got %0d", want.block_surface,
                         got.block_surface);
            end
         end
      end
      rsp_tready <= reset ? 1'b0 : !idle_now();
   end

   always @(posedge clock) begin
      if (cycles > LIMIT_CYCLES) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic req_item_type make_item(logic [2:0] op, logic [5:0] id,
                                              logic signed [19:0] x, logic signed [19:0] y,
                                              logic signed [19:0] z, logic [2:0] s,
                                              logic [23:0] amt);
      req_item_type t;
      t.opcode = op; t.block_id = id; t.px = x; t.py = y; t.pz = z;
      t.surface = s; t.amount = amt;
      return t;
   endfunction

   function automatic logic signed [19:0] rand20();
      return 20'($urandom);
   endfunction

   // Positions kept small so that registered blocks lie near one another.
   function automatic logic signed [19:0] near20();
      return 20'($signed($urandom_range(400)) - 200);
   endfunction

   task automatic drain();
      while (pending_items.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_rsps.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [19:0] v);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= btns_pkg::CSR_ADDR_TOL;
      csr_pwdata <= 32'(v); csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      tolerance = v;
   endtask

   task automatic queue_random(int count);
      req_item_type t;
      logic [2:0] op;
      logic [5:0] id;
      for (int n = 0; n < count; n++) begin
         id = $urandom_range(99) < 85 ? 6'($urandom_range(15)) : 6'($urandom);
         case ($urandom_range(19))
            0, 1, 2, 3:     op = btns_pkg::OP_REGISTER;
            4, 5, 6, 7, 8:  op = btns_pkg::OP_FIND;
            9, 10, 11:      op = btns_pkg::OP_ADD_E;
            12, 13, 14:     op = btns_pkg::OP_ADD_P;
            15:             op = btns_pkg::OP_CLEAR;
            16, 17:         op = btns_pkg::OP_READ;
            default:        op = 3'($urandom);
         endcase
         if ($urandom_range(9) < 8)
            t = make_item(op, id, near20(), near20(), near20(),
                          3'($urandom_range(99) < 92 ? $urandom_range(5) : $urandom),
                          $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(5000)));
         else
            t = make_item(op, id, rand20(), rand20(), rand20(), 3'($urandom), 24'($urandom));
         if (op == btns_pkg::OP_FIND && $urandom_range(1) == 1 && tbl_valid[id]) begin
            // Aim the query at a registered block, slightly off.
            t.px = 20'(tbl_gx[id] + $signed($urandom_range(60)) - 30);
            t.py = 20'(tbl_gy[id] + $signed($urandom_range(60)) - 30);
            t.pz = 20'(tbl_gz[id]);
         end
         enqueue(t);
      end
   endtask

   initial begin
      for (int i = 0; i < 64; i++) begin
         tbl_valid[i] = 1'b0; tbl_surf[i] = '0;
         tbl_gx[i] = '0; tbl_gy[i] = '0; tbl_gz[i] = '0;
         tbl_energy[i] = '0; tbl_photons[i] = '0;
      end
      tolerance = 20'd1600;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part: every surface, both field extremes and the error cases.
      enqueue(make_item(btns_pkg::OP_READ, 6'd3, '0, '0, '0, btns_pkg::SURF_TOP, '0));
      enqueue(make_item(btns_pkg::OP_FIND, 6'd0, '0, '0, '0, btns_pkg::SURF_TOP, '0));
      for (int s = 0; s < 8; s++)
         enqueue(make_item(btns_pkg::OP_REGISTER, 6'(s), 20'sh7FFFF, 20'sh80000,
                           20'sh7FFFF, 3'(s), '0));
      enqueue(make_item(btns_pkg::OP_REGISTER, 6'd63, 20'sh80000, 20'sh7FFFF,
                        20'sh80000, btns_pkg::SURF_BACK, 24'hFFFFFF));
      enqueue(make_item(btns_pkg::OP_REGISTER, 6'd10, 20'sd0, 20'sd0, 20'sd0,
                        btns_pkg::SURF_TOP, '0));
      enqueue(make_item(btns_pkg::OP_REGISTER, 6'd11, 20'sd0, 20'sd0, 20'sd0,
                        btns_pkg::SURF_TOP, '0));
      enqueue(make_item(btns_pkg::OP_FIND, 6'd5, 20'sd0, 20'sd240, 20'sd0,
                        btns_pkg::SURF_TOP, '0));
      enqueue(make_item(btns_pkg::OP_FIND, 6'd5, 20'sd0, 20'sd2000, 20'sd0,
                        btns_pkg::SURF_TOP, '0));
      for (int k = 0; k < 3; k++)
         enqueue(make_item(btns_pkg::OP_ADD_P, 6'd63, '0, '0, '0, '0, 24'hFFFFFF));
      enqueue(make_item(btns_pkg::OP_ADD_E, 6'd63, '0, '0, '0, '0, 24'hFFFFFF));
      enqueue(make_item(btns_pkg::OP_ADD_E, 6'd20, '0, '0, '0, '0, 24'd5));
      enqueue(make_item(btns_pkg::OP_READ, 6'd63, '0, '0, '0, '0, '0));
      enqueue(make_item(btns_pkg::OP_CLEAR, 6'd42, '0, '0, '0, '0, '0));
      enqueue(make_item(btns_pkg::OP_READ, 6'd63, '0, '0, '0, '0, '0));
      enqueue(make_item(OP_BAD6, 6'd1, '0, '0, '0, '0, '0));
      enqueue(make_item(OP_BAD7, 6'd2, '0, '0, '0, '0, '0));
      drive_go = 1'b1;
      drain();

      write_tolerance(20'hFFFFF);
      queue_random(300);
      drain();
      write_tolerance(20'd0);
      queue_random(150);
      drain();
      write_tolerance(20'd1);
      queue_random(150);
      drain();
      write_tolerance(20'($urandom_range(50, 4000)));
      calm = 1'b1;
      queue_random(250);
      while (pending_items.size() != 0) @(posedge clock);
      calm = 1'b0;
      queue_random(300);
      drain();
      write_tolerance(20'd1600);
      queue_random(300);
      drain();

      if (failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

### files.f
hw/rtl/btns_pkg.sv
hw/rtl/btns_dist.sv
hw/rtl/block_table_nearest_search.sv
dv/testbench.sv
